[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held low
`define BDLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define BDLP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// Widths, register indexes, reset values and item types of the key debouncer.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int KEY_W     = 4;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 1;

    // all key lines high: nothing pressed
    localparam logic [KEY_W-1:0] NO_KEY = 4'hF;

    localparam logic [CNT_W-1:0] PRESS_TICKS_RST = 10'd5;
    localparam logic [CNT_W-1:0] LONG_TICKS_RST  = 10'd40;
    localparam logic [CNT_W-1:0] REPEAT_FLOOR    = 10'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 1'd1;

    typedef struct packed {
        logic [KEY_W-1:0] keys;
        logic             set_accelerate;
    } t_item;

    typedef struct packed {
        logic [KEY_W-1:0] key_pattern;
        logic             long_press;
    } t_result;

endpackage

[rtl/bdlp_key_if.sv]
// ----------------------------------------------------------------------------
// bdlp_key_if
// Key sample channel: valid, ready and one sample per transfer.
// ----------------------------------------------------------------------------
interface bdlp_key_if;
    logic                       valid;
    logic                       ready;
    logic [bdlp_pkg::KEY_W-1:0] keys;
    logic                       set_accelerate;

    modport source (output valid, keys, set_accelerate, input ready);
    modport sink   (input valid, keys, set_accelerate, output ready);
endinterface

[rtl/bdlp_res_if.sv]
// ----------------------------------------------------------------------------
// bdlp_res_if
// Press report channel: valid, ready and one report per transfer.
// ----------------------------------------------------------------------------
interface bdlp_res_if;
    logic                       valid;
    logic                       ready;
    logic [bdlp_pkg::KEY_W-1:0] key_pattern;
    logic                       long_press;

    modport source (output valid, key_pattern, long_press, input ready);
    modport sink   (input valid, key_pattern, long_press, output ready);
endinterface

[rtl/bdlp_in_stage.sv]
// ----------------------------------------------------------------------------
// bdlp_in_stage
// Input register: holds one key sample until the core takes it.
// ----------------------------------------------------------------------------
module bdlp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bdlp_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output bdlp_pkg::t_item o_item
);
    import bdlp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // free when empty or when the held sample moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

[rtl/bdlp_core.sv]
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce state, hold counting, auto-repeat and the configuration registers.
// ----------------------------------------------------------------------------
module bdlp_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdlp_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                            i_go,
    input  bdlp_pkg::t_item                 i_item,
    output logic                            o_res_valid,
    output bdlp_pkg::t_result               o_res
);
    import bdlp_pkg::*;

    logic [CNT_W-1:0] r_press_ticks;
    logic [CNT_W-1:0] r_long_ticks;

    logic [KEY_W-1:0] r_last_pattern, n_last_pattern;
    logic [CNT_W-1:0] r_press_count,  n_press_count;
    logic [CNT_W-1:0] r_hold_count,   n_hold_count;
    logic             r_long_reported, n_long_reported;
    logic [CNT_W-1:0] r_repeat_limit, n_repeat_limit;
    logic             r_accelerate,   n_accelerate;

    logic             acc;
    logic             release_tick;
    logic             short_hit;
    logic             long_hit;
    logic [CNT_W-1:0] press_inc;
    logic [CNT_W-1:0] hold_inc;
    logic [CNT_W-1:0] halved;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks <= PRESS_TICKS_RST;
            r_long_ticks  <= LONG_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRESS_TICKS: r_press_ticks <= i_cfg_data;
                REG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign acc          = r_accelerate || i_item.set_accelerate;
    assign release_tick = (i_item.keys == NO_KEY) || (i_item.keys != r_last_pattern);
    assign press_inc    = r_press_count + 1'b1;
    assign hold_inc     = r_hold_count + 1'b1;
    assign halved       = {1'b0, r_repeat_limit[CNT_W-1:1]};

    // per-sample state update and report decision
    always_comb begin
        n_last_pattern  = r_last_pattern;
        n_press_count   = r_press_count;
        n_hold_count    = r_hold_count;
        n_long_reported = r_long_reported;
        n_repeat_limit  = r_repeat_limit;
        n_accelerate    = r_accelerate;
        short_hit       = 1'b0;
        long_hit        = 1'b0;
        if (i_go) begin
            n_last_pattern = i_item.keys;
            if (release_tick) begin
                // pattern change or release: report the previous pattern if it qualifies
                short_hit       = ((r_press_count >= r_press_ticks) || (r_hold_count != '0))
                                  && !r_long_reported;
                long_hit        = r_hold_count >= r_repeat_limit;
                n_accelerate    = 1'b0;
                n_long_reported = 1'b0;
                n_repeat_limit  = r_long_ticks;
                n_press_count   = '0;
                n_hold_count    = '0;
            end else begin
                n_accelerate  = acc;
                n_press_count = press_inc;
                if (press_inc >= r_press_ticks) begin
                    // one hold unit done
                    n_press_count = '0;
                    n_hold_count  = hold_inc;
                    if (hold_inc >= r_repeat_limit) begin
                        n_hold_count    = '0;
                        long_hit        = 1'b1;
                        n_long_reported = 1'b1;
                        if (acc) begin
                            n_repeat_limit = (halved <= REPEAT_FLOOR) ? REPEAT_FLOOR : halved;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pattern  <= NO_KEY;
            r_press_count   <= '0;
            r_hold_count    <= '0;
            r_long_reported <= 1'b0;
            r_repeat_limit  <= LONG_TICKS_RST;
            r_accelerate    <= 1'b0;
        end else begin
            r_last_pattern  <= n_last_pattern;
            r_press_count   <= n_press_count;
            r_hold_count    <= n_hold_count;
            r_long_reported <= n_long_reported;
            r_repeat_limit  <= n_repeat_limit;
            r_accelerate    <= n_accelerate;
        end
    end

    assign o_res_valid       = short_hit || long_hit;
    assign o_res.key_pattern = r_last_pattern;
    assign o_res.long_press  = long_hit;
endmodule

[rtl/bdlp_out_reg.sv]
// ----------------------------------------------------------------------------
// bdlp_out_reg
// Result register: holds a report until the sink takes it.
// ----------------------------------------------------------------------------
module bdlp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bdlp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output bdlp_pkg::t_result o_res
);
    import bdlp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room for a new report when empty or when the held one is taken
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

[rtl/button_debounce_long_press_repeat.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// Key debouncer with short press, long press and accelerated auto-repeat.
//
// One active-low 4-bit key sample is taken per transfer, one per clock at
// full rate; the only hold-off is a full input register behind a result the
// sink has not taken. A sample waits in the input register; as it moves
// on, the debounce state updates and any report lands in the result
// register at that same clock edge, where it stays until the sink takes
// it. Write press_ticks (index 0) and long_ticks (index 1) only while
// idle; a new long_ticks takes effect at the next release or pattern
// change.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdlp_pkg::CNT_W-1:0]      i_cfg_data,
    bdlp_key_if.sink                        i_key,
    bdlp_res_if.source                      o_res
);
    import bdlp_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    core_valid;
    t_result core_res;
    t_result out_res;

    assign in_item.keys           = i_key.keys;
    assign in_item.set_accelerate = i_key.set_accelerate;

    // input register
    bdlp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_key.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_key.ready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // debounce and repeat state
    bdlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_go        (stage_valid && advance),
        .i_item      (stage_item),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // result register
    bdlp_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (stage_valid && core_valid),
        .i_res     (core_res),
        .i_ready   (o_res.ready),
        .o_advance (advance),
        .o_valid   (o_res.valid),
        .o_res     (out_res)
    );

    assign o_res.key_pattern = out_res.key_pattern;
    assign o_res.long_press  = out_res.long_press;
endmodule

[rtl/bdlp_checker.sv]
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the key debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdlp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bdlp_pkg::KEY_W-1:0] i_key_pattern,
    input logic                       i_long_press
);
    // a report waiting on the sink keeps its contents
    `BDLP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_key_pattern) && $stable(i_long_press), "report changed while stalled")

    // reset leaves no report behind
    `BDLP_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "report present after reset")

    // a new report needs a sample transfer ahead of it through the input register
    `BDLP_ASSERT(a_out_cause, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "report without a sample")

    // with no report pending the input never stalls
    `BDLP_ASSERT(a_in_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")
endmodule

bind button_debounce_long_press_repeat bdlp_checker u_bdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_key.valid),
    .i_in_ready    (i_key.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_key_pattern (o_res.key_pattern),
    .i_long_press  (o_res.long_press)
);

[dv/button_debounce_long_press_repeat_test.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_test
// Self-checking bench for the key debouncer. Key samples go in through the
// sample channel with bursty timing, and press reports are taken with a
// stalling sink. A behavioral copy of the debounce counters predicts every
// report, and each report is checked field by field in arrival order. The
// run steps through several press_ticks / long_ticks settings, the largest
// values included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bdlp_pkg::*;

// predicted debounce state and the press reports still owed by the block
class key_press_board;
    logic [CNT_W-1:0] press_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [KEY_W-1:0] last_pattern;
    logic [CNT_W-1:0] press_cnt;
    logic [CNT_W-1:0] hold_cnt;
    logic [CNT_W-1:0] repeat_limit;
    bit               long_seen;
    bit               accel;
    t_result          pending[$];
    int unsigned      errors;

    function new();
        press_ticks  = PRESS_TICKS_RST;
        long_ticks   = LONG_TICKS_RST;
        last_pattern = NO_KEY;
        press_cnt    = '0;
        hold_cnt     = '0;
        repeat_limit = LONG_TICKS_RST;
        long_seen    = 1'b0;
        accel        = 1'b0;
        errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        case (idx)
            REG_PRESS_TICKS: press_ticks = val;
            REG_LONG_TICKS:  long_ticks  = val;
            default: ;
        endcase
    endfunction

    // one accepted key sample: advance the counters, queue any report
    function void note_sample(t_item s);
        logic [KEY_W-1:0] pat;
        bit               fire;
        bit               is_long;
        pat     = s.keys;
        fire    = 1'b0;
        is_long = 1'b0;
        if (s.set_accelerate)
            accel = 1'b1;
        if (pat == NO_KEY || pat != last_pattern) begin
            // release or pattern change
            accel = 1'b0;
            if ((press_cnt >= press_ticks || hold_cnt != 0) && !long_seen) begin
                fire    = 1'b1;
                is_long = 1'b0;
            end
            if (hold_cnt >= repeat_limit) begin
                fire    = 1'b1;
                is_long = 1'b1;
            end
            long_seen    = 1'b0;
            repeat_limit = long_ticks;
            press_cnt    = '0;
            hold_cnt     = '0;
        end else begin
            // stable pattern: count ticks, then hold units
            press_cnt = press_cnt + 1'b1;
            if (press_cnt >= press_ticks) begin
                press_cnt = '0;
                hold_cnt  = hold_cnt + 1'b1;
                if (hold_cnt >= repeat_limit) begin
                    hold_cnt  = '0;
                    fire      = 1'b1;
                    is_long   = 1'b1;
                    long_seen = 1'b1;
                    if (accel) begin
                        repeat_limit = repeat_limit >> 1;
                        if (repeat_limit <= REPEAT_FLOOR)
                            repeat_limit = REPEAT_FLOOR;
                    end
                end
            end
        end
        if (fire)
            pending.push_back('{key_pattern: last_pattern, long_press: is_long});
        last_pattern = pat;
    endfunction

    // one accepted report against the oldest prediction
    function void check_report(t_result got);
        t_result want;
        if (pending.size() == 0) begin
            $error("unexpected report: key_pattern %h long_press %0d",
                   got.key_pattern, got.long_press);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.key_pattern !== want.key_pattern) begin
            $error("key_pattern: expected %h, actual %h", want.key_pattern, got.key_pattern);
            errors++;
        end
        if (got.long_press !== want.long_press) begin
            $error("long_press: expected %0d, actual %0d", want.long_press, got.long_press);
            errors++;
        end
    endfunction
endclass

module button_debounce_long_press_repeat_test;

    localparam int WATCHDOG_CYCLES  = 4000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CNT_W-1:0]     cfg_data;

    bdlp_key_if key_if();
    bdlp_res_if res_if();

    key_press_board board = new();

    int          burst_left;
    int          n_sent;
    int unsigned idle_cycles;
    bit          long_hold_req;

    button_debounce_long_press_repeat i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_key      (key_if),
        .o_res      (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // report side: ready follows a randomly redrawn mode, or is held low for a long hold-off
    initial begin
        int unsigned cyc;
        int          mode;
        cyc  = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                // long hold-off so the block backs up into the sample side
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (cyc % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    2:       res_if.ready <= (cyc % 4 == 0);
                    default: res_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
                cyc++;
            end
        end
    end

    // check every report transfer
    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.key_pattern = res_if.key_pattern;
                got.long_press  = res_if.long_press;
                board.check_report(got);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("button_debounce_long_press_repeat_test failed");
                $finish;
            end
        end
    end

    // one key sample transfer, with bursts and random gaps in front
    task automatic send_sample(input logic [KEY_W-1:0] keys, input logic acc);
        int    gap;
        t_item it;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                key_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 30);
        end
        burst_left--;
        it.keys           = keys;
        it.set_accelerate = acc;
        @(negedge i_clk);
        key_if.valid          <= 1'b1;
        key_if.keys           <= keys;
        key_if.set_accelerate <= acc;
        do @(posedge i_clk); while (key_if.ready !== 1'b1);
        board.note_sample(it);
        n_sent++;
    endtask

    // hold one pattern for some ticks, acceleration asked on at most one of them
    task automatic hold_pattern(input logic [KEY_W-1:0] keys, input int ticks,
                                input int acc_at);
        for (int i = 0; i < ticks; i++)
            send_sample(keys, i == acc_at);
    endtask

    // stop sending until every report is in, then let the pipeline settle
    task automatic drain_and_settle();
        @(negedge i_clk);
        key_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    task automatic set_timing(input int press, input int long_units);
        write_reg(REG_PRESS_TICKS, CNT_W'(press));
        write_reg(REG_LONG_TICKS, CNT_W'(long_units));
    endtask

    // random presses: mostly clean holds and releases, some bounce noise
    task automatic random_presses(input int n);
        int               stop;
        int               units;
        int               press;
        int               d;
        int               acc_at;
        logic [KEY_W-1:0] pat;
        stop  = n_sent + n;
        press = int'(board.press_ticks);
        units = press * int'(board.long_ticks);
        while (n_sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_sample(KEY_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end else begin
                pat = KEY_W'($urandom_range(0, 14));
                case ($urandom_range(0, 3))
                    0:       d = $urandom_range(1, press + 1);
                    1:       d = $urandom_range(press, units + press);
                    2:       d = $urandom_range(units, 3 * units + 2);
                    default: d = $urandom_range(1, 8);
                endcase
                // keep holds short where the thresholds are huge
                if (d > 60 && units > 300)
                    d = $urandom_range(1, 60);
                acc_at = $urandom_range(0, 1) ? $urandom_range(0, d - 1) : -1;
                hold_pattern(pat, d, acc_at);
                if ($urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 4))
                        send_sample(NO_KEY, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_PRESS_TICKS;
        cfg_data              = '0;
        key_if.valid          = 1'b0;
        key_if.keys           = NO_KEY;
        key_if.set_accelerate = 1'b0;
        res_if.ready          = 1'b0;
        burst_left            = 0;
        n_sent                = 0;
        long_hold_req         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short press, accelerated repeats, change of pattern
        set_timing(1, 4);
        send_sample(NO_KEY, 1'b1);          // acceleration asked while idle
        hold_pattern(4'h0, 2, -1);          // every key down
        send_sample(NO_KEY, 1'b0);          // short press of all keys
        hold_pattern(4'hE, 7, 1);           // repeats, limit halves to the floor
        hold_pattern(4'h7, 2, -1);          // change after a long report: silent
        send_sample(4'h8, 1'b1);            // change with acceleration asked
        hold_pattern(4'h8, 4, -1);          // plain long report
        send_sample(NO_KEY, 1'b0);
        drain_and_settle();

        // smallest thresholds of the run, with a long stall on the report side
        set_timing(1, 2);
        long_hold_req = 1'b1;
        random_presses(160);
        drain_and_settle();

        set_timing(3, 5);
        random_presses(80);
        drain_and_settle();
        random_presses(80);
        drain_and_settle();

        // largest thresholds: one hold long enough for a single hold unit
        set_timing(1023, 1023);
        hold_pattern(4'h3, 1025, -1);
        send_sample(NO_KEY, 1'b0);
        random_presses(40);
        drain_and_settle();

        set_timing(2, 3);
        random_presses(160);
        drain_and_settle();

        set_timing(4, 6);
        random_presses(160);
        drain_and_settle();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("button_debounce_long_press_repeat_test passed");
        else
            $display("button_debounce_long_press_repeat_test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/bdlp_key_if.sv
rtl/bdlp_res_if.sv
rtl/bdlp_in_stage.sv
rtl/bdlp_core.sv
rtl/bdlp_out_reg.sv
rtl/button_debounce_long_press_repeat.sv
rtl/bdlp_checker.sv
dv/button_debounce_long_press_repeat_test.sv
